@@ sv/assert_macros.svh @@
// assertion macros for the banker's safety check block
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define BSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// implication checked in the cycle after the trigger
`define BSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/bsc_pkg.sv @@
// shared types and constants for the banker's safety check block
// no dependencies
`default_nettype none

package bsc_pkg;

  localparam int MAX_PROCS_DEF  = 16;
  localparam int MAX_RES_DEF    = 8;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KIND_W     = 2;
  localparam int PIDX_W     = 4;
  localparam int RIDX_W     = 3;
  localparam int AMOUNT_W   = 16;
  localparam int ID_W       = 4;
  localparam int NPROCS_W   = 5;
  localparam int NRES_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_RES   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_CLAIM = 2'd1,
    KIND_AVAIL = 2'd2,
    KIND_RUN   = 2'd3
  } bsc_kind_e;

  typedef struct packed {
    logic avail_we;
    logic init;
    logic step;
    logic commit;
  } bsc_work_cmd_t;

endpackage

`default_nettype wire

@@ sv/bsc_table_mem.sv @@
// allocation and maximum-claim table memory, one word per process and resource
// each half written on its own, with per-entry valid flags so reset reads as zero
`default_nettype none

module bsc_table_mem #(
  parameter int DEPTH = bsc_pkg::MAX_PROCS_DEF * bsc_pkg::MAX_RES_DEF,
  parameter int CW    = bsc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                we_alloc_i,
  input  wire logic                                we_claim_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [CW-1:0]                       wdata_i,
  input  wire logic                                re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [CW-1:0]                       alloc_o,
  output logic      [CW-1:0]                       claim_o
);

  logic [2*CW-1:0] mem_q [DEPTH];
  logic [2*CW-1:0] rdata_q;
  logic [DEPTH-1:0] alloc_vld_q, claim_vld_q;
  logic alloc_rvld_q, claim_rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_alloc_i) begin
      mem_q[waddr_i][CW-1:0] <= wdata_i;
    end
    if (we_claim_i) begin
      mem_q[waddr_i][2*CW-1:CW] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_vld_q  <= '0;
      claim_vld_q  <= '0;
      alloc_rvld_q <= 1'b0;
      claim_rvld_q <= 1'b0;
    end else begin
      if (we_alloc_i) begin
        alloc_vld_q[waddr_i] <= 1'b1;
      end
      if (we_claim_i) begin
        claim_vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        alloc_rvld_q <= alloc_vld_q[raddr_i];
        claim_rvld_q <= claim_vld_q[raddr_i];
      end
    end
  end

  assign alloc_o = alloc_rvld_q ? rdata_q[CW-1:0]    : '0;
  assign claim_o = claim_rvld_q ? rdata_q[2*CW-1:CW] : '0;

endmodule

`default_nettype wire

@@ sv/bsc_order_mem.sv @@
// safe order memory, one write and one registered read port
// no dependencies beyond bsc_pkg defaults
`default_nettype none

module bsc_order_mem #(
  parameter int DEPTH = bsc_pkg::MAX_PROCS_DEF,
  parameter int DW    = bsc_pkg::ID_W
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [DW-1:0]                                wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [DW-1:0]                                rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/bsc_work_unit.sv @@
// available and work vectors with the need check and saturating add-back
// depends on bsc_pkg for the command struct
`default_nettype none

module bsc_work_unit #(
  parameter int MAX_RES    = bsc_pkg::MAX_RES_DEF,
  parameter int COUNT_BITS = bsc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire bsc_pkg::bsc_work_cmd_t                         cmd_i,
  input  wire logic [((MAX_RES > 1) ? $clog2(MAX_RES) : 1)-1:0] avail_col_i,
  input  wire logic [COUNT_BITS-1:0]                          avail_data_i,
  input  wire logic [((MAX_RES > 1) ? $clog2(MAX_RES) : 1)-1:0] col_i,
  input  wire logic [COUNT_BITS-1:0]                          alloc_i,
  input  wire logic [COUNT_BITS-1:0]                          claim_i,
  output logic                                                fit_o
);

  localparam int RIW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int WW  = COUNT_BITS + 4;
  localparam int SW  = WW + 1;

  logic [COUNT_BITS-1:0] avail_q [MAX_RES];
  logic [WW-1:0]         work_q  [MAX_RES];
  logic [WW-1:0]         tmp_q   [MAX_RES];
  logic [COUNT_BITS-1:0] need;
  logic [SW-1:0]         sum;
  logic [WW-1:0]         sat;

  always_comb begin
    need  = (claim_i >= alloc_i) ? (claim_i - alloc_i) : (alloc_i - claim_i);
    sum   = SW'(work_q[col_i]) + SW'(alloc_i);
    sat   = sum[WW] ? '1 : sum[WW-1:0];
    fit_o = WW'(need) <= work_q[col_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_RES; j++) begin
        avail_q[j] <= '0;
        work_q[j]  <= '0;
      end
    end else begin
      if (cmd_i.avail_we) begin
        avail_q[avail_col_i] <= avail_data_i;
      end
      if (cmd_i.init) begin
        for (int j = 0; j < MAX_RES; j++) begin
          work_q[j] <= WW'(avail_q[j]);
        end
      end else if (cmd_i.commit) begin
        // the final column's sum lands in the same cycle as the commit
        for (int j = 0; j < MAX_RES; j++) begin
          work_q[j] <= (cmd_i.step && (RIW'(j) == col_i)) ? sat : tmp_q[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      tmp_q[col_i] <= sat;
    end
  end

endmodule

`default_nettype wire

@@ sv/bankers_safety_check_unit.sv @@
// top level of the banker's safety check: command port, config port, run sequencer
// depends on bsc_pkg, bsc_table_mem, bsc_order_mem, bsc_work_unit, assert_macros.svh
//
// usage
//   config word: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; register 0 is the
//   process count, register 1 the resource type count; a word is taken when both are high
//   command word: taken when start_i is high and busy_o is low; kinds 0..2 write one
//   allocation, claim or available entry in that cycle and keep busy_o low, so one
//   load word per cycle is taken
//   run word: busy_o rises for the whole check; each pass scans the processes in order,
//   skips finished ones and sweeps each unfinished one with one table memory read per
//   resource, over the resource count nr in use; up to np+1 passes
//   results: done_o strobes for one cycle per result; a safe run gives np results on
//   consecutive cycles read from the order memory after the final pass, last_o on the
//   final one; an unsafe run gives one result in the cycle after the final pass
//   busy_o falls in the cycle the final result shows, so the next word may follow at once
//   the receiver cannot stall, so results are never held back
//   reset: counts return to one, available counts clear, tables read as zero through
//   per-entry valid flags, so no clearing pass is needed
`default_nettype none
`include "assert_macros.svh"

module bankers_safety_check_unit #(
  parameter int MAX_PROCS  = bsc_pkg::MAX_PROCS_DEF,
  parameter int MAX_RES    = bsc_pkg::MAX_RES_DEF,
  parameter int COUNT_BITS = bsc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bsc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [bsc_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [bsc_pkg::PIDX_W-1:0]       process_index_i,
  input  wire logic [bsc_pkg::RIDX_W-1:0]       resource_index_i,
  input  wire logic [bsc_pkg::AMOUNT_W-1:0]     amount_i,
  output logic                                  done_o,
  output logic                                  safe_o,
  output logic                                  has_process_o,
  output logic      [bsc_pkg::ID_W-1:0]         process_id_o,
  output logic                                  last_o
);

  localparam int PIW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RIW   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int PCW   = $clog2(MAX_PROCS + 1);
  localparam int RCW   = $clog2(MAX_RES + 1);
  localparam int DEPTH = MAX_PROCS * MAX_RES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [PCW-1:0] pi_q, pi_d, np_q, np_d, cnt_q, cnt_d, ek_q, ek_d;
  logic [RCW-1:0] ri_q, ri_d, nr_q, nr_d;
  logic [RIW-1:0] rj_q, rj_d;
  logic rd_vld_q, rd_vld_d, rd_last_q, rd_last_d, fits_q, fits_d;
  logic progress_q, progress_d, e_vld_q, e_vld_d, e_last_q, e_last_d;
  logic [MAX_PROCS-1:0] fin_q, fin_d;
  logic [bsc_pkg::NPROCS_W-1:0] nprocs_cfg_q;
  logic [bsc_pkg::NRES_W-1:0]   nres_cfg_q;
  logic [PCW-1:0] np_clamp;
  logic [RCW-1:0] nr_clamp;

  logic done_q, done_d, safe_q, safe_d, has_q, has_d, last_q, last_d;
  logic [bsc_pkg::ID_W-1:0] pid_q, pid_d;

  logic load_acc, run_acc, p_ok, r_ok;
  logic tbl_we_alloc, tbl_we_claim, tbl_re;
  logic [AW-1:0] tbl_waddr, tbl_raddr;
  logic [COUNT_BITS-1:0] tbl_wdata, alloc, claim;
  logic ord_we, ord_re;
  logic [PIW-1:0] ord_waddr, ord_raddr;
  logic [bsc_pkg::ID_W-1:0] ord_wdata, ord_rdata;
  bsc_pkg::bsc_work_cmd_t cmd;
  logic [RIW-1:0] wcol;
  logic fit;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = !busy_o;

  // count registers, zero taken as one and large values as the maximum
  always_comb begin
    if (nprocs_cfg_q == '0) begin
      np_clamp = PCW'(1);
    end else if (32'(nprocs_cfg_q) > MAX_PROCS) begin
      np_clamp = PCW'(MAX_PROCS);
    end else begin
      np_clamp = PCW'(nprocs_cfg_q);
    end
    if (nres_cfg_q == '0) begin
      nr_clamp = RCW'(1);
    end else if (32'(nres_cfg_q) > MAX_RES) begin
      nr_clamp = RCW'(MAX_RES);
    end else begin
      nr_clamp = RCW'(nres_cfg_q);
    end
  end

  // load word decode
  always_comb begin
    load_acc     = start_i && !busy_o && (kind_i != bsc_pkg::KIND_RUN);
    run_acc      = start_i && !busy_o && (kind_i == bsc_pkg::KIND_RUN);
    p_ok         = 32'(process_index_i) < MAX_PROCS;
    r_ok         = 32'(resource_index_i) < MAX_RES;
    tbl_we_alloc = load_acc && (kind_i == bsc_pkg::KIND_ALLOC) && p_ok && r_ok;
    tbl_we_claim = load_acc && (kind_i == bsc_pkg::KIND_CLAIM) && p_ok && r_ok;
    tbl_waddr    = AW'(32'(process_index_i) * MAX_RES + 32'(resource_index_i));
    tbl_wdata    = COUNT_BITS'(amount_i);
    wcol         = RIW'(resource_index_i);
    tbl_raddr    = AW'(32'(pi_q) * MAX_RES + 32'(ri_q));
    ord_waddr    = cnt_q[PIW-1:0];
    ord_wdata    = bsc_pkg::ID_W'(pi_q);
    ord_raddr    = ek_q[PIW-1:0];
  end

  always_comb begin
    state_d    = state_q;
    pi_d       = pi_q;
    np_d       = np_q;
    nr_d       = nr_q;
    cnt_d      = cnt_q;
    ek_d       = ek_q;
    ri_d       = ri_q;
    rj_d       = rj_q;
    rd_vld_d   = 1'b0;
    rd_last_d  = rd_last_q;
    fits_d     = fits_q;
    progress_d = progress_q;
    e_vld_d    = 1'b0;
    e_last_d   = e_last_q;
    fin_d      = fin_q;
    done_d     = 1'b0;
    safe_d     = safe_q;
    has_d      = has_q;
    pid_d      = pid_q;
    last_d     = last_q;
    tbl_re     = 1'b0;
    ord_we     = 1'b0;
    ord_re     = 1'b0;
    cmd.avail_we = load_acc && (kind_i == bsc_pkg::KIND_AVAIL) && r_ok;
    cmd.init     = 1'b0;
    cmd.step     = 1'b0;
    cmd.commit   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (run_acc) begin
          np_d       = np_clamp;
          nr_d       = nr_clamp;
          cmd.init   = 1'b1;
          fin_d      = '0;
          cnt_d      = '0;
          pi_d       = '0;
          progress_d = 1'b0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pi_q == np_q) begin
          if (progress_q) begin
            pi_d       = '0;
            progress_d = 1'b0;
          end else if (cnt_q == np_q) begin
            ek_d    = '0;
            state_d = S_EMIT;
          end else begin
            done_d  = 1'b1;
            safe_d  = 1'b0;
            has_d   = 1'b0;
            pid_d   = '0;
            last_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (fin_q[pi_q[PIW-1:0]]) begin
          pi_d = pi_q + 1'b1;
        end else begin
          ri_d    = '0;
          fits_d  = 1'b1;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (ri_q != nr_q) begin
          tbl_re    = 1'b1;
          rd_vld_d  = 1'b1;
          rj_d      = ri_q[RIW-1:0];
          rd_last_d = (ri_q == nr_q - 1'b1);
          ri_d      = ri_q + 1'b1;
        end
        if (rd_vld_q) begin
          cmd.step = 1'b1;
          fits_d   = fits_q && fit;
          if (rd_last_q) begin
            if (fits_q && fit) begin
              cmd.commit             = 1'b1;
              fin_d[pi_q[PIW-1:0]]   = 1'b1;
              ord_we                 = 1'b1;
              cnt_d                  = cnt_q + 1'b1;
              progress_d             = 1'b1;
            end
            pi_d    = pi_q + 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_EMIT: begin
        if (ek_q != cnt_q) begin
          ord_re   = 1'b1;
          e_vld_d  = 1'b1;
          e_last_d = (ek_q == cnt_q - 1'b1);
          ek_d     = ek_q + 1'b1;
        end
        if (e_vld_q) begin
          done_d = 1'b1;
          safe_d = 1'b1;
          has_d  = 1'b1;
          pid_d  = ord_rdata;
          last_d = e_last_q;
          if (e_last_q) begin
            state_d = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pi_q         <= '0;
      np_q         <= PCW'(1);
      nr_q         <= RCW'(1);
      cnt_q        <= '0;
      ek_q         <= '0;
      ri_q         <= '0;
      rj_q         <= '0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      fits_q       <= 1'b0;
      progress_q   <= 1'b0;
      e_vld_q      <= 1'b0;
      e_last_q     <= 1'b0;
      fin_q        <= '0;
      done_q       <= 1'b0;
      nprocs_cfg_q <= bsc_pkg::NPROCS_W'(1);
      nres_cfg_q   <= bsc_pkg::NRES_W'(1);
    end else begin
      state_q    <= state_d;
      pi_q       <= pi_d;
      np_q       <= np_d;
      nr_q       <= nr_d;
      cnt_q      <= cnt_d;
      ek_q       <= ek_d;
      ri_q       <= ri_d;
      rj_q       <= rj_d;
      rd_vld_q   <= rd_vld_d;
      rd_last_q  <= rd_last_d;
      fits_q     <= fits_d;
      progress_q <= progress_d;
      e_vld_q    <= e_vld_d;
      e_last_q   <= e_last_d;
      fin_q      <= fin_d;
      done_q     <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          bsc_pkg::CFG_NUM_PROCS: nprocs_cfg_q <= cfg_data_i[bsc_pkg::NPROCS_W-1:0];
          bsc_pkg::CFG_NUM_RES:   nres_cfg_q   <= cfg_data_i[bsc_pkg::NRES_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    safe_q <= safe_d;
    has_q  <= has_d;
    pid_q  <= pid_d;
    last_q <= last_d;
  end

  assign done_o        = done_q;
  assign safe_o        = safe_q;
  assign has_process_o = has_q;
  assign process_id_o  = pid_q;
  assign last_o        = last_q;

  bsc_table_mem #(
    .DEPTH (DEPTH),
    .CW    (COUNT_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_alloc_i (tbl_we_alloc),
    .we_claim_i (tbl_we_claim),
    .waddr_i    (tbl_waddr),
    .wdata_i    (tbl_wdata),
    .re_i       (tbl_re),
    .raddr_i    (tbl_raddr),
    .alloc_o    (alloc),
    .claim_o    (claim)
  );

  bsc_order_mem #(
    .DEPTH (MAX_PROCS),
    .DW    (bsc_pkg::ID_W)
  ) u_order (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  bsc_work_unit #(
    .MAX_RES    (MAX_RES),
    .COUNT_BITS (COUNT_BITS)
  ) u_work (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .avail_col_i  (wcol),
    .avail_data_i (tbl_wdata),
    .col_i        (rj_q),
    .alloc_i      (alloc),
    .claim_i      (claim),
    .fit_o        (fit)
  );

  `BSC_ASSERT(a_fin_count, $countones(fin_q) == 32'(cnt_q), "finished flags and count disagree")
  `BSC_ASSERT(a_done_from_run, done_o |-> $past(busy_o), "result word without a run")
  `BSC_ASSERT(a_last_frees, (done_o && last_o) |-> !busy_o, "busy held after final result")
  `BSC_ASSERT_NEXT(a_sweep_room, state_q == S_SCAN && state_d == S_SWEEP,
                   cnt_q < np_q, "sweep started with every process finished")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// testbench for bankers_safety_check_unit: directed and random command words, with a
// built-in predictor of the safe order and a checker on every result word
// depends on bsc_pkg and the block's rtl only

module tb;
  import bsc_pkg::*;

  localparam int NPROC          = MAX_PROCS_DEF;
  localparam int NRES           = MAX_RES_DEF;
  localparam int ITEM_TARGET    = 220;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [19:0] WORK_SAT = 20'hFFFFF;

  typedef struct {
    logic            safe;
    logic            has_process;
    logic [ID_W-1:0] process_id;
    logic            last;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  start_i;
  logic                  busy_o;
  logic [KIND_W-1:0]     kind_i;
  logic [PIDX_W-1:0]     process_index_i;
  logic [RIDX_W-1:0]     resource_index_i;
  logic [AMOUNT_W-1:0]   amount_i;
  logic                  done_o;
  logic                  safe_o;
  logic                  has_process_o;
  logic [ID_W-1:0]       process_id_o;
  logic                  last_o;

  // predictor state
  logic [AMOUNT_W-1:0] held_units  [NPROC][NRES];
  logic [AMOUNT_W-1:0] claim_units [NPROC][NRES];
  logic [AMOUNT_W-1:0] free_units  [NRES];
  logic [NPROCS_W-1:0] proc_count;
  logic [NRES_W-1:0]   res_type_count;

  verdict_t verdict_q [$];
  int       mismatches;
  int       items_sent;
  int       quiet_cycles;
  bit       gaps_on;

  bankers_safety_check_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .process_index_i  (process_index_i),
    .resource_index_i (resource_index_i),
    .amount_i         (amount_i),
    .done_o           (done_o),
    .safe_o           (safe_o),
    .has_process_o    (has_process_o),
    .process_id_o     (process_id_o),
    .last_o           (last_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int clamp_count(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic run_safety_check();
    logic [19:0] work [NRES];
    bit          finished [NPROC];
    int          order [$];
    int          np;
    int          nr;
    bit          fits;
    bit          progress;
    logic [AMOUNT_W-1:0] need;
    logic [20:0] sum;
    verdict_t    v;
    np = clamp_count(int'(proc_count), NPROC);
    nr = clamp_count(int'(res_type_count), NRES);
    for (int j = 0; j < NRES; j++) work[j] = {4'd0, free_units[j]};
    for (int i = 0; i < NPROC; i++) finished[i] = 1'b0;
    do begin
      progress = 1'b0;
      for (int i = 0; i < np; i++) begin
        if (!finished[i]) begin
          fits = 1'b1;
          for (int j = 0; j < nr; j++) begin
            need = (claim_units[i][j] >= held_units[i][j]) ?
                   claim_units[i][j] - held_units[i][j] : held_units[i][j] - claim_units[i][j];
            if ({4'd0, need} > work[j]) fits = 1'b0;
          end
          if (fits) begin
            for (int j = 0; j < nr; j++) begin
              sum = {1'b0, work[j]} + {5'd0, held_units[i][j]};
              work[j] = (sum > {1'b0, WORK_SAT}) ? WORK_SAT : sum[19:0];
            end
            finished[i] = 1'b1;
            order.push_back(i);
            progress = 1'b1;
          end
        end
      end
    end while (progress);
    if (order.size() < np) begin
      v.safe = 1'b0;
      v.has_process = 1'b0;
      v.process_id = '0;
      v.last = 1'b1;
      verdict_q.push_back(v);
    end else begin
      for (int k = 0; k < order.size(); k++) begin
        v.safe = 1'b1;
        v.has_process = 1'b1;
        v.process_id = order[k][ID_W-1:0];
        v.last = (k == order.size() - 1);
        verdict_q.push_back(v);
      end
    end
  endtask

  task automatic idle_burst();
    int n = $urandom_range(1, 17);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic send_word(input bsc_kind_e k, input logic [PIDX_W-1:0] p,
                           input logic [RIDX_W-1:0] r, input logic [AMOUNT_W-1:0] amt);
    if (gaps_on && $urandom_range(0, 3) == 0) idle_burst();
    @(negedge clk_i);
    start_i          <= 1'b1;
    kind_i           <= k;
    process_index_i  <= p;
    resource_index_i <= r;
    amount_i         <= amt;
    do @(posedge clk_i); while (busy_o);
    case (k)
      KIND_ALLOC: held_units[p][r] = amt;
      KIND_CLAIM: claim_units[p][r] = amt;
      KIND_AVAIL: free_units[r] = amt;
      KIND_RUN:   run_safety_check();
    endcase
    items_sent++;
  endtask

  task automatic wait_until_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_NUM_PROCS) proc_count = val;
    else res_type_count = val[NRES_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] np, input logic [CFG_DATA_W-1:0] nr);
    wait_until_idle();
    write_reg(CFG_NUM_PROCS, np);
    write_reg(CFG_NUM_RES, nr);
  endtask

  task automatic test_reset_state();
    send_word(KIND_RUN, 4'd0, 3'd0, 16'd0);
  endtask

  task automatic test_claim_below_alloc();
    configure(5'd0, 5'd0);
    send_word(KIND_ALLOC, 4'd0, 3'd0, 16'hFFFF);
    send_word(KIND_CLAIM, 4'd0, 3'd0, 16'h0000);
    send_word(KIND_AVAIL, 4'd0, 3'd0, 16'h0000);
    send_word(KIND_RUN, 4'd0, 3'd0, 16'h0000);
    send_word(KIND_AVAIL, 4'd0, 3'd0, 16'hFFFF);
    send_word(KIND_RUN, 4'd15, 3'd7, 16'hFFFF);
  endtask

  task automatic test_multi_pass_order();
    configure(5'd2, 5'd1);
    send_word(KIND_AVAIL, 4'd0, 3'd0, 16'd1);
    send_word(KIND_ALLOC, 4'd1, 3'd0, 16'hFFFF);
    send_word(KIND_CLAIM, 4'd1, 3'd0, 16'hFFFE);
    send_word(KIND_RUN, 4'd0, 3'd0, 16'd0);
  endtask

  task automatic test_count_clamping();
    configure(5'd31, 5'd15);
    send_word(KIND_RUN, 4'd0, 3'd0, 16'd0);
  endtask

  task automatic test_resource_range();
    configure(5'd16, 5'd8);
    send_word(KIND_CLAIM, 4'd3, 3'd7, 16'd5);
    send_word(KIND_AVAIL, 4'd0, 3'd7, 16'd4);
    send_word(KIND_RUN, 4'd0, 3'd0, 16'd0);
    configure(5'd16, 5'd7);
    send_word(KIND_RUN, 4'd0, 3'd0, 16'd0);
  endtask

  function automatic int random_count(input int maxv, input int top);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return top;
      2:       return maxv;
      3:       return $urandom_range(maxv + 1, top);
      default: return $urandom_range(1, maxv);
    endcase
  endfunction

  task automatic test_random_mix();
    int np;
    int nr;
    int style;
    logic [PIDX_W-1:0]   p;
    logic [RIDX_W-1:0]   r;
    logic [AMOUNT_W-1:0] held;
    while (items_sent < ITEM_TARGET) begin
      configure(5'(random_count(NPROC, 31)),
                {1'($urandom_range(0, 1)), 4'(random_count(NRES, 15))});
      np = clamp_count(int'(proc_count), NPROC);
      nr = clamp_count(int'(res_type_count), NRES);
      gaps_on = (items_sent < ITEM_TARGET - 40) && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        style = $urandom_range(0, 19);
        if (style < 14) begin
          // consistent claims with small needs
          repeat ($urandom_range(1, 4)) begin
            p = PIDX_W'($urandom_range(0, np - 1));
            r = RIDX_W'($urandom_range(0, nr - 1));
            held = AMOUNT_W'($urandom_range(0, 6));
            send_word(KIND_ALLOC, p, r, held);
            send_word(KIND_CLAIM, p, r, held + 16'($urandom_range(0, 4)));
          end
          if ($urandom_range(0, 1))
            send_word(KIND_AVAIL, 4'($urandom), 3'($urandom_range(0, nr - 1)),
                      16'($urandom_range(0, 8)));
        end else if (style < 19) begin
          repeat ($urandom_range(1, 5))
            send_word(bsc_kind_e'($urandom_range(0, 3)), 4'($urandom), 3'($urandom),
                      $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7)));
        end else begin
          // whole column at full scale, drives the work counts toward saturation, reached with the full process count
          r = RIDX_W'($urandom_range(0, nr - 1));
          for (int i = 0; i < np; i++) begin
            send_word(KIND_ALLOC, 4'(i), r, 16'hFFFF);
            send_word(KIND_CLAIM, 4'(i), r, 16'hFFFF - 16'($urandom_range(0, 2)));
          end
          send_word(KIND_AVAIL, 4'd0, r, 16'hFFFF);
        end
        send_word(KIND_RUN, 4'($urandom), 3'($urandom), 16'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result word: safe %0d process_id %0d", safe_o, process_id_o);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (safe_o !== want.safe) begin
          $error("safe: expected %0d, got %0d", want.safe, safe_o);
          mismatches++;
        end
        if (has_process_o !== want.has_process) begin
          $error("has_process: expected %0d, got %0d", want.has_process, has_process_o);
          mismatches++;
        end
        if (process_id_o !== want.process_id) begin
          $error("process_id: expected %0d, got %0d", want.process_id, process_id_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_NUM_PROCS;
    cfg_data_i       = '0;
    start_i          = 1'b0;
    kind_i           = KIND_ALLOC;
    process_index_i  = '0;
    resource_index_i = '0;
    amount_i         = '0;
    quiet_cycles     = 0;
    mismatches       = 0;
    items_sent       = 0;
    gaps_on          = 1'b1;
    proc_count       = 5'd1;
    res_type_count   = 4'd1;
    for (int i = 0; i < NPROC; i++)
      for (int j = 0; j < NRES; j++) begin
        held_units[i][j]  = '0;
        claim_units[i][j] = '0;
      end
    for (int j = 0; j < NRES; j++) free_units[j] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_claim_below_alloc();
    test_multi_pass_order();
    test_count_clamping();
    test_resource_range();
    test_random_mix();
    wait_until_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
